// File: src/mtps_pkg.sv
// Shared types, constants and register codes for the multi-threshold pulse scaler.
package mtps_pkg;

  localparam int DEF_THRESHOLD_COUNT = 512;
  localparam int DEF_SAMPLE_BITS     = 14;

  localparam int SAMPLE_W = 14;
  localparam int AMP_W    = 15;
  localparam int LEVEL_W  = 20;
  localparam int COUNT_W  = 32;
  localparam int IDX_W    = 9;
  localparam int BASE_W   = 14;
  localparam int SPACE_W  = 10;
  localparam int POS_W    = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = 3'd5;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] sample_value;
    logic                event_begin;
    logic [IDX_W-1:0]    read_index;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]   threshold_index;
    logic [LEVEL_W-1:0] threshold_level;
    logic [COUNT_W-1:0] pulse_count;
  } out_word_t;

  typedef struct packed {
    logic [BASE_W-1:0]  baseline_level;
    logic               invert_polarity;
    logic [BASE_W-1:0]  lowest_threshold;
    logic [SPACE_W-1:0] threshold_spacing;
    logic [POS_W-1:0]   window_start;
    logic [POS_W-1:0]   window_end;
  } cfg_regs_t;

  // one queued operation from the front to the back
  typedef struct packed {
    logic                    is_read;
    logic signed [AMP_W-1:0] amp;
    logic signed [AMP_W-1:0] prev_amp;
    logic                    evaluate;
    logic                    event_begin;
    logic [IDX_W-1:0]        read_index;
    logic [LEVEL_W-1:0]      read_level;
  } op_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

// File: src/mtps_front.sv
// Front end: classifies words, forms amplitude, tracks position and previous amplitude.
module mtps_front #(
  parameter int SAMPLE_BITS = mtps_pkg::DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mtps_pkg::cfg_regs_t    cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mtps_pkg::in_word_t     in_data,
  input  logic                   q_full,
  input  mtps_pkg::back_status_t bk_status,
  output logic                   q_push,
  output mtps_pkg::op_t          q_op
);
  import mtps_pkg::*;

  localparam logic [SAMPLE_W-1:0] SMASK =
    (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic signed [AMP_W-1:0] prev_r, prev_nxt;
  logic [POS_W-1:0]        pos_cur;
  logic [SAMPLE_W-1:0]     smp;
  logic signed [AMP_W-1:0] diff, amp;
  logic [18:0]             prod;
  logic                    is_sample;

  assign in_ready  = !q_full && !bk_status.clearing;
  assign q_push    = in_valid && in_ready;
  assign is_sample = (in_data.cmd == CMD_SAMPLE);

  always_comb begin
    smp     = in_data.sample_value & SMASK;
    diff    = $signed({1'b0, smp}) - $signed({1'b0, cfg.baseline_level});
    amp     = cfg.invert_polarity ? -diff : diff;
    pos_cur = in_data.event_begin ? '0 : pos_r;
    prod    = 19'(in_data.read_index) * 19'(cfg.threshold_spacing);

    q_op.is_read     = (in_data.cmd == CMD_READ);
    q_op.amp         = amp;
    q_op.prev_amp    = prev_r;
    q_op.evaluate    = (pos_cur != '0) && (pos_cur >= cfg.window_start)
                       && (pos_cur < cfg.window_end);
    q_op.event_begin = in_data.event_begin;
    q_op.read_index  = in_data.read_index;
    q_op.read_level  = LEVEL_W'(cfg.lowest_threshold) + LEVEL_W'(prod);

    pos_nxt  = pos_r;
    prev_nxt = prev_r;
    if (q_push && is_sample) begin
      prev_nxt = amp;
      pos_nxt  = (pos_cur == {POS_W{1'b1}}) ? pos_cur : pos_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      prev_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule

// File: src/mtps_fifo.sv
// Two-entry queue of operations between front and back.
module mtps_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mtps_pkg::op_t push_op,
  input  logic          pop,
  output mtps_pkg::op_t head_op,
  output logic          full,
  output logic          empty
);
  import mtps_pkg::*;

  op_t        slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head_op = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: src/mtps_back.sv
// Back end: walks the flag/count memory per sample, serves count reads, clears after reset.
module mtps_back #(
  parameter int THRESHOLD_COUNT = mtps_pkg::DEF_THRESHOLD_COUNT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mtps_pkg::cfg_regs_t    cfg,
  input  mtps_pkg::op_t          head_op,
  input  logic                   q_empty,
  output logic                   q_pop,
  output mtps_pkg::back_status_t bk_status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mtps_pkg::out_word_t    out_data
);
  import mtps_pkg::*;

  localparam int IW = (THRESHOLD_COUNT > 1) ? $clog2(THRESHOLD_COUNT) : 1;
  localparam int MW = COUNT_W + 1;   // flag on top of the count

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  logic [MW-1:0] mem [THRESHOLD_COUNT];
  logic [MW-1:0] rdata_r;

  logic [1:0]              st_r, st_nxt;
  logic [IW-1:0]           clr_idx_r, clr_idx_nxt;
  logic [IW:0]             issue_r, issue_nxt;
  logic [IW-1:0]           proc_idx_r, proc_idx_nxt;
  logic                    proc_v_r, proc_v_nxt;
  logic [LEVEL_W-1:0]      lvl_r, lvl_nxt;
  logic                    fclr_r, fclr_nxt;
  logic signed [AMP_W-1:0] amp_r, amp_nxt, prev_r, prev_nxt;
  logic [IDX_W-1:0]        ridx_r, ridx_nxt;
  logic [LEVEL_W-1:0]      rlvl_r, rlvl_nxt;
  logic                    rin_r, rin_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_r, out_nxt;

  logic                    rd_en, wr_en;
  logic [IW-1:0]           rd_addr, wr_addr;
  logic [MW-1:0]           wr_data;
  logic                    flag_in, flag_out;
  logic [COUNT_W-1:0]      cnt_in, cnt_out;
  logic signed [20:0]      amp_x, prev_x, thr_x;
  logic                    in_range;

  assign bk_status.clearing = (st_r == ST_CLR);
  assign out_valid          = out_valid_r;
  assign out_data           = out_r;
  assign in_range           = 32'(head_op.read_index) < 32'(THRESHOLD_COUNT);

  // per-threshold update of the word read last cycle
  always_comb begin
    flag_in  = fclr_r ? 1'b0 : rdata_r[COUNT_W];
    cnt_in   = rdata_r[COUNT_W-1:0];
    amp_x    = 21'(amp_r);
    prev_x   = 21'(prev_r);
    thr_x    = $signed({1'b0, lvl_r});
    flag_out = flag_in;
    cnt_out  = cnt_in;
    if (!flag_in) begin
      if (amp_x > thr_x && amp_x > prev_x) begin
        flag_out = 1'b1;
        if (cnt_in != {COUNT_W{1'b1}}) cnt_out = cnt_in + 1'b1;
      end
    end else if (amp_x < thr_x && amp_x < prev_x) begin
      flag_out = 1'b0;
    end
  end

  always_comb begin
    st_nxt        = st_r;
    clr_idx_nxt   = clr_idx_r;
    issue_nxt     = issue_r;
    proc_idx_nxt  = proc_idx_r;
    proc_v_nxt    = 1'b0;
    lvl_nxt       = lvl_r;
    fclr_nxt      = fclr_r;
    amp_nxt       = amp_r;
    prev_nxt      = prev_r;
    ridx_nxt      = ridx_r;
    rlvl_nxt      = rlvl_r;
    rin_nxt       = rin_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = issue_r[IW-1:0];
    wr_en         = 1'b0;
    wr_addr       = proc_idx_r;
    wr_data       = {flag_out, cnt_out};

    unique case (st_r)
      ST_CLR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        wr_data     = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IW'(THRESHOLD_COUNT - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (head_op.is_read) begin
            rd_en    = in_range;
            rd_addr  = IW'(head_op.read_index);
            ridx_nxt = head_op.read_index;
            rlvl_nxt = head_op.read_level;
            rin_nxt  = in_range;
            st_nxt   = ST_READ;
          end else if (head_op.evaluate) begin
            amp_nxt   = head_op.amp;
            prev_nxt  = head_op.prev_amp;
            lvl_nxt   = LEVEL_W'(cfg.lowest_threshold);
            issue_nxt = '0;
            st_nxt    = ST_WALK;
          end else if (head_op.event_begin) begin
            fclr_nxt = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (issue_r < (IW+1)'(THRESHOLD_COUNT)) begin
          rd_en        = 1'b1;
          issue_nxt    = issue_r + 1'b1;
          proc_v_nxt   = 1'b1;
          proc_idx_nxt = issue_r[IW-1:0];
        end
        if (proc_v_r) begin
          wr_en   = 1'b1;
          lvl_nxt = lvl_r + LEVEL_W'(cfg.threshold_spacing);
          if (proc_idx_r == IW'(THRESHOLD_COUNT - 1)) begin
            fclr_nxt = 1'b0;
            st_nxt   = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_nxt.threshold_index = ridx_r;
          out_nxt.threshold_level = rlvl_r;
          out_nxt.pulse_count     = rin_r ? rdata_r[COUNT_W-1:0] : '0;
          st_nxt                  = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    amp_r      <= amp_nxt;
    prev_r     <= prev_nxt;
    lvl_r      <= lvl_nxt;
    issue_r    <= issue_nxt;
    proc_idx_r <= proc_idx_nxt;
    ridx_r     <= ridx_nxt;
    rlvl_r     <= rlvl_nxt;
    rin_r      <= rin_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLR;
      clr_idx_r   <= '0;
      proc_v_r    <= 1'b0;
      fclr_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_idx_r   <= clr_idx_nxt;
      proc_v_r    <= proc_v_nxt;
      fclr_r      <= fclr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/multi_threshold_pulse_scaler.sv
// Top level of the multi-threshold pulse scaler: config registers, front, queue, back.
//
// Usage: words on the in_ channel either feed one sample (cmd 0) or ask for the
// count of one threshold (cmd 1). Sample words produce no output; each read word
// produces one out_ word with the index, its threshold level and its count.
// Registers are written on the cfg_ channel (always ready); the user must write
// them only while the block is idle: the block itself does not enforce this.
// The front passes each accepted word into a two-entry queue. An evaluated sample
// walks every threshold in the back end, one threshold per cycle through the
// flag/count memory (one read and one write port). With the back end idle, a read
// word passes the queue, ST_READ and the output register before out_valid rises.
// Reset: synchronous; afterwards a clearing pass zeroes the memory, and in_ready
// stays low until it ends.
// Stall: a result waits in the output register while out_ready is low; the queue
// keeps accepting words until it fills.
module multi_threshold_pulse_scaler #(
  parameter int THRESHOLD_COUNT = mtps_pkg::DEF_THRESHOLD_COUNT,
  parameter int SAMPLE_BITS     = mtps_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mtps_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mtps_pkg::out_word_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mtps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mtps_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mtps_pkg::*;

  cfg_regs_t    cfg_r, cfg_nxt;
  op_t          push_op, head_op;
  logic         q_push, q_pop, q_full, q_empty;
  back_status_t bk_status;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BASELINE:  cfg_nxt.baseline_level    = cfg_data[BASE_W-1:0];
        CFG_INVERT:    cfg_nxt.invert_polarity   = cfg_data[0];
        CFG_LOWEST:    cfg_nxt.lowest_threshold  = cfg_data[BASE_W-1:0];
        CFG_SPACING:   cfg_nxt.threshold_spacing = cfg_data[SPACE_W-1:0];
        CFG_WIN_START: cfg_nxt.window_start      = cfg_data[POS_W-1:0];
        CFG_WIN_END:   cfg_nxt.window_end        = cfg_data[POS_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.baseline_level    <= '0;
      cfg_r.invert_polarity   <= 1'b0;
      cfg_r.lowest_threshold  <= BASE_W'(5);
      cfg_r.threshold_spacing <= SPACE_W'(5);
      cfg_r.window_start      <= '0;
      cfg_r.window_end        <= {POS_W{1'b1}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mtps_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .bk_status (bk_status),
    .q_push    (q_push),
    .q_op      (push_op)
  );

  mtps_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .head_op (head_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  mtps_back #(
    .THRESHOLD_COUNT(THRESHOLD_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head_op   (head_op),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .bk_status (bk_status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: test/tb_multi_threshold_pulse_scaler.sv
// Testbench for the multi-threshold pulse scaler: directed table, random events, count checks.
module tb_multi_threshold_pulse_scaler;
  import mtps_pkg::*;

  localparam int NTHR          = DEF_THRESHOLD_COUNT;
  localparam int SETTLE_CYCLES = 3 * (NTHR + 2) + 8;
  localparam int TIMEOUT_UNITS = 16_000_000;
  localparam int PROBE_N       = 20;

  typedef struct packed {
    in_word_t  w;
    logic      fixed;
    out_word_t want;
  } probe_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BASELINE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // shadow copy of the scaler state
  cfg_regs_t          shadow_cfg;
  bit                 flag_bank [NTHR];
  logic [COUNT_W-1:0] count_bank [NTHR];
  int                 prev_amp;
  int                 sample_pos;
  out_word_t          owed_reports [$];
  out_word_t          next_report;

  int words_sent      = 0;
  int reads_sent      = 0;
  int reports_checked = 0;
  int mismatches      = 0;
  int settings_run    = 0;

  probe_row_t probe_rows [PROBE_N];

  multi_threshold_pulse_scaler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("timeout with %0d reports outstanding", owed_reports.size());
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [LEVEL_W-1:0] level_at(input logic [IDX_W-1:0] idx);
    int lv;
    lv = int'(shadow_cfg.lowest_threshold) + int'(idx) * int'(shadow_cfg.threshold_spacing);
    return lv[LEVEL_W-1:0];
  endfunction

  function automatic void scale_word(input in_word_t w, output bit has_report,
                                     output out_word_t report);
    int amp;
    int thr;
    has_report = 1'b0;
    report = '0;
    if (w.cmd == CMD_READ) begin
      has_report = 1'b1;
      report.threshold_index = w.read_index;
      report.threshold_level = level_at(w.read_index);
      report.pulse_count     = count_bank[w.read_index];
    end else begin
      if (w.event_begin) begin
        sample_pos = 0;
        foreach (flag_bank[j]) flag_bank[j] = 1'b0;
      end
      amp = int'(w.sample_value) - int'(shadow_cfg.baseline_level);
      if (shadow_cfg.invert_polarity) amp = -amp;
      if (sample_pos != 0 && sample_pos >= int'(shadow_cfg.window_start) &&
          sample_pos < int'(shadow_cfg.window_end)) begin
        for (int j = 0; j < NTHR; j++) begin
          thr = int'(level_at(IDX_W'(j)));
          if (!flag_bank[j]) begin
            if (amp > thr && amp > prev_amp) begin
              if (count_bank[j] != '1) count_bank[j] = count_bank[j] + 1'b1;
              flag_bank[j] = 1'b1;
            end
          end else if (amp < thr && amp < prev_amp) begin
            flag_bank[j] = 1'b0;
          end
        end
      end
      prev_amp = amp;
      if (sample_pos < 65535) sample_pos++;
    end
  endfunction

  // valid is only dropped when the sender idles, so back-to-back words keep it high
  task automatic send_word(input in_word_t w, input bit fixed, input out_word_t want);
    bit        has_report;
    out_word_t report;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    scale_word(w, has_report, report);
    if (has_report) owed_reports.push_back(fixed ? want : report);
    words_sent++;
    if (w.cmd == CMD_READ) reads_sent++;
  endtask

  task automatic drain(input bit settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_reports.size() != 0) @(posedge clk);
    // samples give no report, the back end may still be walking the bank
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BASELINE:  shadow_cfg.baseline_level    = val[BASE_W-1:0];
      CFG_INVERT:    shadow_cfg.invert_polarity   = val[0];
      CFG_LOWEST:    shadow_cfg.lowest_threshold  = val[BASE_W-1:0];
      CFG_SPACING:   shadow_cfg.threshold_spacing = val[SPACE_W-1:0];
      CFG_WIN_START: shadow_cfg.window_start      = val[POS_W-1:0];
      CFG_WIN_END:   shadow_cfg.window_end        = val[POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input cfg_regs_t c);
    write_reg(CFG_BASELINE,  CFG_DATA_W'(c.baseline_level));
    write_reg(CFG_INVERT,    CFG_DATA_W'(c.invert_polarity));
    write_reg(CFG_LOWEST,    CFG_DATA_W'(c.lowest_threshold));
    write_reg(CFG_SPACING,   CFG_DATA_W'(c.threshold_spacing));
    write_reg(CFG_WIN_START, CFG_DATA_W'(c.window_start));
    write_reg(CFG_WIN_END,   CFG_DATA_W'(c.window_end));
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // mostly short events of random amplitudes around the threshold bank, plus reads and noise
  task automatic run_phase(input cfg_regs_t c, input int n_items, input int idle_pct,
                           input int stall_pct, input bit pause_midway);
    in_word_t w;
    int       left_in_event;
    int       top;
    int       amp;
    int       s;
    int       roll;
    drain(1'b1);
    set_config(c);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    left_in_event  = 0;
    top = int'(level_at(IDX_W'(NTHR - 1)));
    if (top > 16500) top = 16500;
    for (int n = 0; n < n_items; n++) begin
      if (pause_midway && n == n_items / 2) drain(1'b0);
      roll = $urandom_range(99);
      w = '0;
      w.read_index   = IDX_W'($urandom);
      w.sample_value = SAMPLE_W'($urandom);
      if (roll < 30) begin
        w.cmd         = CMD_READ;
        w.event_begin = 1'($urandom);
        if ($urandom_range(1)) w.read_index = IDX_W'($urandom_range(31));
      end else if (roll < 38) begin
        w.cmd         = CMD_SAMPLE;
        w.event_begin = ($urandom_range(3) == 0);
      end else begin
        w.cmd         = CMD_SAMPLE;
        w.event_begin = (left_in_event == 0);
        if (left_in_event == 0) left_in_event = $urandom_range(14, 2);
        left_in_event--;
        amp = int'($urandom_range(top + 150)) - 100;
        s = shadow_cfg.invert_polarity ? int'(shadow_cfg.baseline_level) - amp
                                       : int'(shadow_cfg.baseline_level) + amp;
        if (s < 0) s = 0;
        if (s > 16383) s = 16383;
        w.sample_value = s[SAMPLE_W-1:0];
      end
      send_word(w, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                             input logic [COUNT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (owed_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none got index %0d level %0d count %0d",
                 $time, out_data.threshold_index, out_data.threshold_level,
                 out_data.pulse_count);
      end else begin
        next_report = owed_reports.pop_front();
        check_field("threshold_index", COUNT_W'(next_report.threshold_index),
                    COUNT_W'(out_data.threshold_index));
        check_field("threshold_level", COUNT_W'(next_report.threshold_level),
                    COUNT_W'(out_data.threshold_level));
        check_field("pulse_count", next_report.pulse_count, out_data.pulse_count);
        reports_checked++;
      end
    end
  end

  initial begin
    probe_rows = '{
      // reads straight after reset: levels of the reset bank, counts zero
      {CMD_READ,   14'd0,     1'b0, 9'd0,   1'b1, 9'd0,   20'd5,    32'd0},
      {CMD_READ,   14'd0,     1'b0, 9'd511, 1'b1, 9'd511, 20'd2560, 32'd0},
      {CMD_READ,   14'd16383, 1'b1, 9'd341, 1'b1, 9'd341, 20'd1710, 32'd0},
      {CMD_SAMPLE, 14'd0,     1'b1, 9'd0,   1'b0, 9'd0,   20'd0,    32'd0},
      // equal to the lowest threshold: not above it
      {CMD_SAMPLE, 14'd5,     1'b0, 9'd0,   1'b0, 9'd0,   20'd0,    32'd0},
      {CMD_READ,   14'd0,     1'b0, 9'd0,   1'b0, 9'd0,   20'd0,    32'd0},
      {CMD_SAMPLE, 14'd16383, 1'b0, 9'd511, 1'b0, 9'd0,   20'd0,    32'd0},
      {CMD_SAMPLE, 14'd16383, 1'b0, 9'd0,   1'b0, 9'd0,   20'd0,    32'd0},
      {CMD_READ,   14'd0,     1'b0, 9'd511, 1'b0, 9'd0,   20'd0,    32'd0},
      {CMD_SAMPLE, 14'd0,     1'b0, 9'd0,   1'b0, 9'd0,   20'd0,    32'd0},
      {CMD_SAMPLE, 14'd100,   1'b0, 9'd0,   1'b0, 9'd0,   20'd0,    32'd0},
      {CMD_READ,   14'd0,     1'b0, 9'd18,  1'b0, 9'd0,   20'd0,    32'd0},
      {CMD_READ,   14'd0,     1'b0, 9'd19,  1'b0, 9'd0,   20'd0,    32'd0},
      // new event: flags drop, sample only seeds the previous amplitude
      {CMD_SAMPLE, 14'd100,   1'b1, 9'd0,   1'b0, 9'd0,   20'd0,    32'd0},
      {CMD_SAMPLE, 14'd16383, 1'b0, 9'd0,   1'b0, 9'd0,   20'd0,    32'd0},
      {CMD_READ,   14'd0,     1'b0, 9'd0,   1'b0, 9'd0,   20'd0,    32'd0},
      {CMD_SAMPLE, 14'd16383, 1'b1, 9'd0,   1'b0, 9'd0,   20'd0,    32'd0},
      {CMD_SAMPLE, 14'd16383, 1'b0, 9'd0,   1'b0, 9'd0,   20'd0,    32'd0},
      {CMD_READ,   14'd0,     1'b0, 9'd200, 1'b0, 9'd0,   20'd0,    32'd0},
      {CMD_READ,   14'd16383, 1'b1, 9'd170, 1'b0, 9'd0,   20'd0,    32'd0}
    };
    shadow_cfg = cfg_regs_t'({14'd0, 1'b0, 14'd5, 10'd5, 16'd0, 16'd65535});
    foreach (count_bank[j]) count_bank[j] = '0;
    foreach (flag_bank[j]) flag_bank[j] = 1'b0;
    prev_amp   = 0;
    sample_pos = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PROBE_N; r++)
      send_word(probe_rows[r].w, probe_rows[r].fixed, probe_rows[r].want);

    run_phase(cfg_regs_t'({14'd0, 1'b0, 14'd5, 10'd5, 16'd0, 16'd65535}), 210, 0, 0, 1'b0);
    run_phase(cfg_regs_t'({14'd8192, 1'b1, 14'd0, 10'd0, 16'd0, 16'd65535}), 200, 79, 0, 1'b0);
    run_phase(cfg_regs_t'({14'd16383, 1'b1, 14'd100, 10'd31, 16'd2, 16'd9}), 250, 0, 79, 1'b1);
    run_phase(cfg_regs_t'({14'd1000, 1'b0, 14'd16383, 10'd1023, 16'd5, 16'd5}), 60, 30, 30,
              1'b0);
    run_phase(cfg_regs_t'({14'd300, 1'b0, 14'd20, 10'd1, 16'd3, 16'd65535}), 250, 30, 30, 1'b0);
    run_phase(cfg_regs_t'({14'd1000, 1'b0, 14'd0, 10'd7, 16'd65535, 16'd0}), 120, 0, 0, 1'b0);
    run_phase(cfg_regs_t'({14'd12000, 1'b1, 14'd2, 10'd2, 16'd1, 16'd40}), 60, 79, 79, 1'b0);

    drain(1'b1);
    $display("Fed %0d words (%0d count reads) through %0d register settings,",
             words_sent, reads_sent, settings_run);
    $display("with idle and stall mixes; %0d reports checked, %0d mismatches.",
             reports_checked, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
